@@ design/ftws_pkg.sv @@
package ftws_pkg;

  localparam int unsigned HISTORY_DEPTH = 128;
  localparam logic [7:0] WIN_RESET = 8'd60;
  localparam int unsigned RANK_NUM = 99;
  localparam int unsigned RANK_DEN = 100;
  localparam int unsigned SUM_W = 32;

  typedef enum logic [3:0] {
    ST_IDLE, ST_HRD, ST_HWR, ST_DRD, ST_DEX, ST_IRD, ST_IEX, ST_IFIN,
    ST_SRD, ST_SWT, ST_ARD, ST_AEX, ST_DIV, ST_OUT
  } ctrl_state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_HRD, OP_HWR, OP_DRD, OP_DEX, OP_IRD, OP_IEX, OP_IFIN,
    OP_SRD, OP_SWT, OP_ARD, OP_AEX, OP_DIV, OP_OUT
  } dp_op_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic del_last;
    logic ins_stop;
    logic ins_last;
    logic win_zero;
    logic sum_last;
    logic div_last;
  } dp_status_t;

endpackage

@@ design/ftws_ctrl.sv @@
module ftws_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  ftws_pkg::dp_status_t st,
  output ftws_pkg::dp_op_t    op
);

  ftws_pkg::ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ftws_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (op == ftws_pkg::OP_OUT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign in_ready = (state == ftws_pkg::ST_IDLE);

  always_comb begin
    state_next = state;
    op         = ftws_pkg::OP_NONE;
    case (state)
      ftws_pkg::ST_IDLE: begin
        if (in_valid) begin
          op         = ftws_pkg::OP_LOAD;
          state_next = ftws_pkg::ST_HRD;
        end
      end
      ftws_pkg::ST_HRD: begin
        op         = ftws_pkg::OP_HRD;
        state_next = ftws_pkg::ST_HWR;
      end
      ftws_pkg::ST_HWR: begin
        op = ftws_pkg::OP_HWR;
        if (st.full) begin
          state_next = ftws_pkg::ST_DRD;
        end else if (st.empty) begin
          state_next = ftws_pkg::ST_IFIN;
        end else begin
          state_next = ftws_pkg::ST_IRD;
        end
      end
      ftws_pkg::ST_DRD: begin
        op         = ftws_pkg::OP_DRD;
        state_next = ftws_pkg::ST_DEX;
      end
      ftws_pkg::ST_DEX: begin
        op         = ftws_pkg::OP_DEX;
        state_next = st.del_last ? ftws_pkg::ST_IRD : ftws_pkg::ST_DRD;
      end
      ftws_pkg::ST_IRD: begin
        op         = ftws_pkg::OP_IRD;
        state_next = ftws_pkg::ST_IEX;
      end
      ftws_pkg::ST_IEX: begin
        op = ftws_pkg::OP_IEX;
        if (st.ins_stop) begin
          state_next = ftws_pkg::ST_SRD;
        end else if (st.ins_last) begin
          state_next = ftws_pkg::ST_IFIN;
        end else begin
          state_next = ftws_pkg::ST_IRD;
        end
      end
      ftws_pkg::ST_IFIN: begin
        op         = ftws_pkg::OP_IFIN;
        state_next = ftws_pkg::ST_SRD;
      end
      ftws_pkg::ST_SRD: begin
        op         = ftws_pkg::OP_SRD;
        state_next = ftws_pkg::ST_SWT;
      end
      ftws_pkg::ST_SWT: begin
        op         = ftws_pkg::OP_SWT;
        state_next = st.win_zero ? ftws_pkg::ST_OUT : ftws_pkg::ST_ARD;
      end
      ftws_pkg::ST_ARD: begin
        op         = ftws_pkg::OP_ARD;
        state_next = ftws_pkg::ST_AEX;
      end
      ftws_pkg::ST_AEX: begin
        op         = ftws_pkg::OP_AEX;
        state_next = st.sum_last ? ftws_pkg::ST_DIV : ftws_pkg::ST_ARD;
      end
      ftws_pkg::ST_DIV: begin
        op = ftws_pkg::OP_DIV;
        if (st.div_last) begin
          state_next = ftws_pkg::ST_OUT;
        end
      end
      ftws_pkg::ST_OUT: begin
        if (!out_valid || out_ready) begin
          op         = ftws_pkg::OP_OUT;
          state_next = ftws_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ftws_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ design/ftws_dp.sv @@
module ftws_dp #(
  parameter int unsigned DEPTH = ftws_pkg::HISTORY_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ftws_pkg::dp_op_t     op,
  output ftws_pkg::dp_status_t st,
  input  logic                 cfg_wr_en,
  input  logic [7:0]           cfg_wr_data,
  input  logic [23:0]          frame_time_us,
  output logic [23:0]          mean_frame_us,
  output logic [23:0]          slow_frame_us,
  output logic [7:0]           samples_held
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = ftws_pkg::SUM_W;

  logic [23:0]   hist [DEPTH];
  logic [23:0]   srt  [DEPTH];
  logic [23:0]   hist_rdata, srt_rdata;
  logic [AW-1:0] hist_raddr, srt_raddr, srt_waddr;
  logic          hist_re, srt_re, srt_we;
  logic [23:0]   srt_wdata;

  logic [7:0]    win_len;
  logic [23:0]   sample, old, slow;
  logic [AW-1:0] wp, rp;
  logic [CW-1:0] cnt, len, idx, q;
  logic [7:0]    rem;
  logic          found;
  logic [7:0]    win, wcnt;
  logic [SW-1:0] acc, quo;
  logic [7:0]    remd;
  logic [4:0]    dcnt;

  logic [CW-1:0] rank;
  logic [7:0]    rem_inc;
  logic [8:0]    rs;
  logic [7:0]    win_c;
  logic          ins_gt;

  always_comb begin
    rank = (q == '0) ? '0 : q - CW'(1);
    if (rank > cnt - CW'(1)) begin
      rank = cnt - CW'(1);
    end
  end

  assign rem_inc = rem + 8'(ftws_pkg::RANK_NUM);
  assign rs      = {remd, quo[SW-1]};
  assign win_c   = ({{(CW > 8 ? 1 : 9 - CW){1'b0}}, cnt} < {1'b0, win_len}) ?
                   8'(cnt) : win_len;
  assign ins_gt  = srt_rdata > sample;

  always_comb begin
    st.full     = (cnt == CW'(DEPTH));
    st.empty    = (cnt == '0);
    st.del_last = (idx == len - CW'(1));
    st.ins_stop = !ins_gt;
    st.ins_last = (idx == '0);
    st.win_zero = (win == '0);
    st.sum_last = (wcnt == win - 8'd1);
    st.div_last = (dcnt == 5'd31);
  end

  assign hist_re    = (op == ftws_pkg::OP_HRD) || (op == ftws_pkg::OP_ARD);
  assign hist_raddr = (op == ftws_pkg::OP_HRD) ? wp : rp;
  assign srt_re     = (op == ftws_pkg::OP_DRD) || (op == ftws_pkg::OP_IRD) ||
                      (op == ftws_pkg::OP_SRD);
  assign srt_raddr  = (op == ftws_pkg::OP_SRD) ? rank[AW-1:0] : idx[AW-1:0];

  always_comb begin
    srt_we    = 1'b0;
    srt_waddr = '0;
    srt_wdata = sample;
    case (op)
      ftws_pkg::OP_DEX: begin
        srt_we    = found;
        srt_waddr = AW'(idx - CW'(1));
        srt_wdata = srt_rdata;
      end
      ftws_pkg::OP_IEX: begin
        srt_we    = 1'b1;
        srt_waddr = AW'(idx + CW'(1));
        srt_wdata = ins_gt ? srt_rdata : sample;
      end
      ftws_pkg::OP_IFIN: begin
        srt_we = 1'b1;
      end
      default: begin
        srt_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (hist_re) begin
      hist_rdata <= hist[hist_raddr];
    end
    if (op == ftws_pkg::OP_HWR) begin
      hist[wp] <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (srt_re) begin
      srt_rdata <= srt[srt_raddr];
    end
    if (srt_we) begin
      srt[srt_waddr] <= srt_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_len <= ftws_pkg::WIN_RESET;
      wp      <= '0;
      cnt     <= '0;
      q       <= '0;
      rem     <= 8'(ftws_pkg::RANK_NUM);
    end else begin
      if (cfg_wr_en) begin
        win_len <= cfg_wr_data;
      end
      if (op == ftws_pkg::OP_HWR) begin
        wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + AW'(1);
        if (!st.full) begin
          cnt <= cnt + CW'(1);
          if (rem_inc >= 8'(ftws_pkg::RANK_DEN)) begin
            q   <= q + CW'(1);
            rem <= rem_inc - 8'(ftws_pkg::RANK_DEN);
          end else begin
            rem <= rem_inc;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      ftws_pkg::OP_LOAD: begin
        sample <= frame_time_us;
      end
      ftws_pkg::OP_HWR: begin
        old   <= hist_rdata;
        len   <= cnt;
        found <= 1'b0;
        idx   <= st.full ? '0 : cnt - CW'(1);
      end
      ftws_pkg::OP_DEX: begin
        if (!found && srt_rdata == old) begin
          found <= 1'b1;
        end
        if (st.del_last) begin
          idx <= len - CW'(2);
          len <= len - CW'(1);
        end else begin
          idx <= idx + CW'(1);
        end
      end
      ftws_pkg::OP_IEX: begin
        idx <= idx - CW'(1);
      end
      ftws_pkg::OP_SRD: begin
        rp   <= (wp == '0) ? AW'(DEPTH - 1) : wp - AW'(1);
        win  <= win_c;
        wcnt <= '0;
        acc  <= '0;
      end
      ftws_pkg::OP_SWT: begin
        slow <= srt_rdata;
      end
      ftws_pkg::OP_AEX: begin
        acc  <= acc + SW'(hist_rdata);
        rp   <= (rp == '0) ? AW'(DEPTH - 1) : rp - AW'(1);
        wcnt <= wcnt + 8'd1;
        quo  <= acc + SW'(hist_rdata);
        remd <= '0;
        dcnt <= '0;
      end
      ftws_pkg::OP_DIV: begin
        dcnt <= dcnt + 5'd1;
        if (rs >= {1'b0, win}) begin
          remd <= 8'(rs - {1'b0, win});
          quo  <= {quo[SW-2:0], 1'b1};
        end else begin
          remd <= rs[7:0];
          quo  <= {quo[SW-2:0], 1'b0};
        end
      end
      ftws_pkg::OP_OUT: begin
        mean_frame_us <= st.win_zero ? sample : quo[23:0];
        slow_frame_us <= slow;
        samples_held  <= 8'(cnt);
      end
      default: begin
      end
    endcase
  end

endmodule

@@ design/frame_time_window_statistics.sv @@
// Each beat runs the sorted-copy update (one read and one write port, read then write
//   per entry) and, for a non-empty window, the 32-step mean divider; one beat is
//   in flight at a time.
// A new beat is taken while the previous result waits on the output.
// rst (synchronous, active high) empties the history and sets the window to 60.
module frame_time_window_statistics #(
  parameter int unsigned HISTORY_DEPTH = ftws_pkg::HISTORY_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [23:0] frame_time_us
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [23:0] mean_frame_us, [47:24] slow_frame_us,
                                      // [55:48] samples_held
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);

  ftws_pkg::dp_op_t     op;
  ftws_pkg::dp_status_t st;
  logic [23:0] mean_frame_us, slow_frame_us;
  logic [7:0]  samples_held;

  ftws_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .st        (st),
    .op        (op)
  );

  ftws_dp #(
    .DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .op            (op),
    .st            (st),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .frame_time_us (s_axis_tdata),
    .mean_frame_us (mean_frame_us),
    .slow_frame_us (slow_frame_us),
    .samples_held  (samples_held)
  );

  assign m_axis_tdata = {samples_held, slow_frame_us, mean_frame_us};

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while a beat is in progress");

  a_result_frees_input: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> s_axis_tready)
    else $error("result issued without returning to idle");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    (op == ftws_pkg::OP_DIV) |-> !st.win_zero)
    else $error("mean divider run with empty window");
`endif

endmodule
